// ===== hdl/stt_pkg.sv =====
// shared constants and controller/datapath interface types for the timer table
// no dependencies
package stt_pkg;

	// default and upper bound of the table size
	localparam int NUM_TIMERS_DEF = 16;
	localparam int MAX_SLOTS      = 16;

	// input opcodes
	localparam logic [2:0] OP_CREATE  = 3'd0;
	localparam logic [2:0] OP_STOP    = 3'd1;
	localparam logic [2:0] OP_STOPALL = 3'd2;
	localparam logic [2:0] OP_TICK    = 3'd3;
	localparam logic [2:0] OP_QUERY   = 3'd4;

	// result kinds
	localparam logic [2:0] K_CREATED = 3'd0;
	localparam logic [2:0] K_FIRED   = 3'd1;
	localparam logic [2:0] K_DONE    = 3'd2;
	localparam logic [2:0] K_FULL    = 3'd3;
	localparam logic [2:0] K_NEXT    = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic latch;      // capture input word, clear scan index
		logic exec;       // create, stop, stop-all or unknown op and its result
		logic tick_step;  // process one slot of a tick pass
		logic q_step;     // fold one slot into the earliest-due search
		logic put_done;   // done marker closing a tick pass
		logic put_ans;    // query answer
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic op_tick;
		logic op_query;
		logic idx_last;
		logic fire_pend;
		logic out_free;
	} stat_t;

endpackage

// ===== hdl/stt_ctrl.sv =====
// sequencing state machine of the timer table
// depends on stt_pkg
module stt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  stt_pkg::stat_t stat,
	output stt_pkg::cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_TICK  = 6'b000100,
		S_QUERY = 6'b001000,
		S_TDONE = 6'b010000,
		S_QANS  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.op_tick) begin
					state_d = S_TICK;
				end else if (stat.op_query) begin
					state_d = S_QUERY;
				end else if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_TICK: begin
				// a firing slot waits for room in the output register
				if (!stat.fire_pend || stat.out_free) begin
					cmd.tick_step = 1'b1;
					if (stat.idx_last) begin
						state_d = S_TDONE;
					end
				end
			end
			S_QUERY: begin
				cmd.q_step = 1'b1;
				if (stat.idx_last) begin
					state_d = S_QANS;
				end
			end
			S_TDONE: begin
				if (stat.out_free) begin
					cmd.put_done = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_QANS: begin
				if (stat.out_free) begin
					cmd.put_ans = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/stt_datapath.sv =====
// slot table, scan index, earliest-due search and output register
// depends on stt_pkg
module stt_datapath #(
	parameter int NUM_TIMERS = stt_pkg::NUM_TIMERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stt_pkg::cmd_t        cmd,
	output stt_pkg::stat_t       stat,
	input  logic [2:0]           opcode,
	input  logic [3:0]           handle,
	input  logic [31:0]          due_time,
	input  logic [15:0]          reload_interval,
	input  logic [31:0]          now_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           kind,
	output logic [3:0]           slot,
	output logic signed [32:0]   seconds_left,
	output logic                 last
);

	localparam int TS = (NUM_TIMERS > stt_pkg::MAX_SLOTS) ? stt_pkg::MAX_SLOTS : NUM_TIMERS;
	localparam int SW = (TS > 1) ? $clog2(TS) : 1;
	localparam logic [SW-1:0] IDX_LAST = SW'(TS - 1);

	// slot table
	logic [TS-1:0] live_q;
	logic [TS-1:0] stop_q;
	logic [31:0]   due_q [TS];
	logic [15:0]   reload_q [TS];

	// captured input word
	logic [2:0]  op_q;
	logic [3:0]  hnd_q;
	logic [31:0] first_due_q;
	logic [15:0] ivl_q;
	logic [31:0] now_q;

	// scan state
	logic [SW-1:0] idx_q;
	logic          any_q;
	logic [31:0]   min_q;

	// output register
	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [3:0]  slot_q;
	logic [32:0] secs_q;
	logic        last_q;

	logic          cur_live, cur_stop, hit, fire, reload_ok;
	logic [31:0]   cur_due;
	logic [15:0]   cur_ivl;
	logic          free_any;
	logic [SW-1:0] free_idx;
	logic [SW-1:0] hidx;
	logic          hnd_ok;
	logic          out_free, put;
	logic [32:0]   ans;
	logic [2:0]    kind_d;
	logic [3:0]    slot_d;
	logic [32:0]   secs_d;
	logic          last_d;

	assign cur_live  = live_q[idx_q];
	assign cur_stop  = stop_q[idx_q];
	assign cur_due   = due_q[idx_q];
	assign cur_ivl   = reload_q[idx_q];
	assign hit       = cur_live && (cur_due <= now_q);
	assign fire      = hit && !cur_stop;
	assign reload_ok = !cur_stop && (cur_ivl != 16'd0);

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TS - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign hidx   = hnd_q[SW-1:0];
	assign hnd_ok = ({1'b0, hnd_q} < 5'(TS)) && live_q[hidx];

	assign out_free = !out_valid_q || out_ready;

	assign stat.op_tick   = (op_q == stt_pkg::OP_TICK);
	assign stat.op_query  = (op_q == stt_pkg::OP_QUERY);
	assign stat.idx_last  = (idx_q == IDX_LAST);
	assign stat.fire_pend = fire;
	assign stat.out_free  = out_free;

	always_comb begin
		if (!any_q) begin
			ans = '1;
		end else if (min_q < now_q) begin
			ans = '0;
		end else begin
			ans = {1'b0, min_q - now_q};
		end
	end

	assign put = cmd.exec || (cmd.tick_step && fire) || cmd.put_done || cmd.put_ans;

	always_comb begin
		kind_d = stt_pkg::K_DONE;
		slot_d = 4'd0;
		secs_d = '0;
		last_d = 1'b1;
		if (cmd.exec) begin
			if (op_q == stt_pkg::OP_CREATE) begin
				if (free_any) begin
					kind_d = stt_pkg::K_CREATED;
					slot_d = 4'(free_idx);
				end else begin
					kind_d = stt_pkg::K_FULL;
				end
			end
		end else if (cmd.tick_step) begin
			kind_d = stt_pkg::K_FIRED;
			slot_d = 4'(idx_q);
			last_d = 1'b0;
		end else if (cmd.put_ans) begin
			kind_d = stt_pkg::K_NEXT;
			secs_d = ans;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			any_q       <= 1'b0;
		end else begin
			if (put) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.latch) begin
				idx_q <= '0;
				any_q <= 1'b0;
			end else if ((cmd.tick_step || cmd.q_step) && !stat.idx_last) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.q_step && cur_live) begin
				any_q <= 1'b1;
			end
			if (cmd.exec) begin
				case (op_q)
					stt_pkg::OP_CREATE: begin
						if (free_any) begin
							live_q[free_idx] <= 1'b1;
						end
					end
					stt_pkg::OP_STOPALL: begin
						live_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.tick_step && hit && !reload_ok) begin
				live_q[idx_q] <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q        <= opcode;
			hnd_q       <= handle;
			first_due_q <= due_time;
			ivl_q       <= reload_interval;
			now_q       <= now_time;
		end
		if (cmd.q_step && cur_live && (!any_q || cur_due < min_q)) begin
			min_q <= cur_due;
		end
		if (cmd.exec) begin
			case (op_q)
				stt_pkg::OP_CREATE: begin
					if (free_any) begin
						due_q[free_idx]    <= first_due_q;
						reload_q[free_idx] <= ivl_q;
						stop_q[free_idx]   <= 1'b0;
					end
				end
				stt_pkg::OP_STOP: begin
					if (hnd_ok) begin
						due_q[hidx]  <= '0;
						stop_q[hidx] <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.tick_step && hit && reload_ok) begin
			due_q[idx_q] <= cur_due + {16'd0, cur_ivl};
		end
		if (put) begin
			kind_q <= kind_d;
			slot_q <= slot_d;
			secs_q <= secs_d;
			last_q <= last_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign slot         = slot_q;
	assign seconds_left = $signed(secs_q);
	assign last         = last_q;

endmodule

// ===== hdl/software_timer_table.sv =====
// top level of the software timer table: controller plus datapath
// depends on stt_pkg, stt_ctrl, stt_datapath
//
//  channel  | handshake             | word
//  ---------+-----------------------+-------------------------------------------------
//  input    | in_valid / in_ready   | opcode, handle, due_time, reload_interval, now_time
//  output   | out_valid / out_ready | kind, slot, seconds_left, last
//
// create, stop, stop-all and unknown opcodes go from accept through dispatch back to idle, where the next word is taken
// tick and query scan the table_slots slots one slot per cycle, a tick pausing while a fired word waits,
// through the scan index of the slot table, after dispatch and before the closing word
// every result word, fired or final, waits while the output register is still held
// reset clears the live marks, the controller and the output valid; no clearing pass
// a new word is taken while the last result still waits in the output register
module software_timer_table #(
	parameter int NUM_TIMERS = stt_pkg::NUM_TIMERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic [3:0]         handle,
	input  logic [31:0]        due_time,
	input  logic [15:0]        reload_interval,
	input  logic [31:0]        now_time,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         kind,
	output logic [3:0]         slot,
	output logic signed [32:0] seconds_left,
	output logic               last
);

	// command and status between the sequencer and the table
	stt_pkg::cmd_t  cmd;
	stt_pkg::stat_t stat;

	// sequencer: one input word at a time, scans driven one slot per cycle unless a fired word waits
	stt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// slot table, scan logic and the output register
	stt_datapath #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.opcode          (opcode),
		.handle          (handle),
		.due_time        (due_time),
		.reload_interval (reload_interval),
		.now_time        (now_time),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.slot            (slot),
		.seconds_left    (seconds_left),
		.last            (last)
	);

endmodule

// ===== hdl/stt_checker.sv =====
// port-level checks of the timer table, bound to the top level
// depends on stt_pkg and software_timer_table
module stt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [2:0]         kind,
	input logic [3:0]         slot,
	input logic signed [32:0] seconds_left,
	input logic               last
);

	// a held result word does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(slot)
			&& $stable(seconds_left) && $stable(last))
		else $error("output word changed while stalled");

	// the block is busy right after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// fired words never close an item and carry no seconds
	a_fired: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == stt_pkg::K_FIRED |-> !last && seconds_left == 33'sd0)
		else $error("malformed fired word");

	// every other kind is the final word of its item
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == stt_pkg::K_CREATED || kind == stt_pkg::K_DONE
			|| kind == stt_pkg::K_FULL || kind == stt_pkg::K_NEXT) |-> last)
		else $error("final word without last");

endmodule

bind software_timer_table stt_checker u_stt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.slot         (slot),
	.seconds_left (seconds_left),
	.last         (last)
);
